FILE: rtl/core/dsefr_pkg.sv
package dsefr_pkg;

   localparam logic [7:0] SYM_DLE = 8'h10;
   localparam logic [7:0] SYM_STX = 8'h02;
   localparam logic [7:0] SYM_ETX = 8'h03;

   localparam int LEN_W  = 7;
   localparam int WAIT_W = 3;

   typedef enum logic [4:0] {
      PH_IDLE    = 5'b00001,
      PH_GOT_DLE = 5'b00010,
      PH_DATA    = 5'b00100,
      PH_ESCAPE  = 5'b01000,
      PH_SKIP    = 5'b10000
   } phase_type;

endpackage

FILE: rtl/core/dsefr_ram.sv
module dsefr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/dle_stx_etx_frame_receiver_top.sv
// A line byte is taken and gives no result.
// A read request of a stored frame shows its first byte after the slot memory read and the
// output register, then one byte per cycle while the consumer is ready, paced by the slot memory read.
// An empty-ring read shows its single result in the cycle after acceptance.
// Throughput: one line byte per cycle except while a frame is being read out, when no request is taken.
// Reset is synchronous; it clears the parser, ring pointers and flags, not the memories.
module dle_stx_etx_frame_receiver_top #(
   parameter int FRAME_SLOTS = 8,
   parameter int MAX_DATA    = 63
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_kind,
   input  logic [7:0]                       req_line_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_out_byte,
   output logic                             rsp_is_last,
   output logic [dsefr_pkg::LEN_W-1:0]      rsp_frame_length,
   output logic                             rsp_no_frame,
   output logic [dsefr_pkg::WAIT_W-1:0]     rsp_frames_waiting,
   output logic                             rsp_overflow_seen
);

   import dsefr_pkg::*;

   localparam int SW = $clog2(FRAME_SLOTS);
   localparam int KW = $clog2(MAX_DATA + 1);
   localparam int AW = SW + KW;
   localparam logic [SW-1:0] LAST_SLOT = SW'(FRAME_SLOTS - 1);
   localparam logic [KW-1:0] MAX_COUNT = KW'(MAX_DATA);

   phase_type             phase_ff, phase_in;
   logic [7:0]            xor_ff, xor_in;
   logic [KW-1:0]         count_ff, count_in;
   logic [SW-1:0]         head_ff, head_in;
   logic [SW-1:0]         tail_ff, tail_in;
   logic                  drop_ff, drop_in;
   logic                  busy_ff, busy_in;
   logic [SW-1:0]         rd_slot_ff, rd_slot_in;
   logic [KW:0]           fetch_k_ff, fetch_k_in;
   logic [KW-1:0]         data_k_ff, data_k_in;
   logic                  avail_ff, avail_in;
   logic [WAIT_W-1:0]     waiting_ff, waiting_in;
   logic                  ovf_ff, ovf_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            out_byte_ff, out_byte_in;
   logic                  is_last_ff, is_last_in;
   logic [LEN_W-1:0]      length_ff, length_in;
   logic                  no_frame_ff, no_frame_in;
   logic [WAIT_W-1:0]     out_wait_ff, out_wait_in;
   logic                  out_ovf_ff, out_ovf_in;

   logic                  accept, line_acc, read_acc;
   logic                  empty, full;
   logic [SW-1:0]         next_head, next_tail;
   logic [SW:0]           stored;
   logic                  add_en, commit_en;
   logic                  consume, fetch_more, last_byte, load_out;
   logic                  slot_we, slot_re;
   logic [AW-1:0]         slot_waddr, slot_raddr;
   logic [7:0]            slot_wdata, slot_rdata;
   logic                  len_we;
   logic [LEN_W-1:0]      len_wdata, len_rdata;

   assign req_ready = !busy_ff && (!req_kind || !rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign line_acc  = accept && !req_kind;
   assign read_acc  = accept && req_kind;

   assign empty     = (head_ff == tail_ff);
   assign next_head = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
   assign next_tail = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;
   assign full      = (next_head == tail_ff);

   always_comb begin
      if (head_ff >= tail_ff) begin
         stored = {1'b0, head_ff} - {1'b0, tail_ff};
      end else begin
         stored = {1'b0, head_ff} + (SW + 1)'(FRAME_SLOTS) - {1'b0, tail_ff};
      end
   end

   assign consume    = avail_ff && (!rsp_valid_ff || rsp_ready);
   assign fetch_more = busy_ff && (LEN_W'(fetch_k_ff) < len_rdata) && (!avail_ff || consume);
   assign last_byte  = (LEN_W'(data_k_ff) + LEN_W'(1)) == len_rdata;
   assign load_out   = consume || (read_acc && empty);

   always_comb begin
      phase_in  = phase_ff;
      xor_in    = xor_ff;
      count_in  = count_ff;
      add_en    = 1'b0;
      commit_en = 1'b0;
      if (line_acc) begin
         unique case (phase_ff)
            PH_GOT_DLE: begin
               phase_in = (req_line_byte == SYM_STX) ? PH_DATA : PH_IDLE;
            end
            PH_DATA: begin
               if (req_line_byte == SYM_DLE) begin
                  phase_in = PH_ESCAPE;
               end else begin
                  add_en = 1'b1;
               end
            end
            PH_ESCAPE: begin
               if (req_line_byte == SYM_ETX) begin
                  commit_en = 1'b1;
               end else if (req_line_byte == SYM_DLE) begin
                  add_en = 1'b1;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            PH_SKIP: begin
               phase_in = PH_IDLE;
            end
            default: begin
               if (req_line_byte == SYM_DLE) begin
                  xor_in   = '0;
                  count_in = '0;
                  phase_in = PH_GOT_DLE;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
         endcase
         if (add_en) begin
            if (count_ff >= MAX_COUNT) begin
               add_en   = 1'b0;
               count_in = '0;
               phase_in = PH_IDLE;
            end else begin
               count_in = count_ff + 1'b1;
               xor_in   = xor_ff ^ req_line_byte;
               phase_in = PH_DATA;
            end
         end
         if (commit_en) begin
            count_in = '0;
            phase_in = PH_SKIP;
         end
      end
   end

   // The slot at the head is never part of the ring, so a frame is assembled in place.
   assign slot_we    = add_en || commit_en;
   assign slot_waddr = {head_ff, count_ff};
   assign slot_wdata = commit_en ? xor_ff : req_line_byte;
   assign len_we     = commit_en && !full;
   assign len_wdata  = LEN_W'(count_ff) + LEN_W'(1);

   assign slot_re    = (read_acc && !empty) || fetch_more;
   assign slot_raddr = read_acc ? {tail_ff, KW'(0)} : {rd_slot_ff, fetch_k_ff[KW-1:0]};

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      drop_in      = drop_ff;
      busy_in      = busy_ff;
      rd_slot_in   = rd_slot_ff;
      fetch_k_in   = fetch_k_ff;
      data_k_in    = data_k_ff;
      avail_in     = avail_ff;
      waiting_in   = waiting_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      out_byte_in  = out_byte_ff;
      is_last_in   = is_last_ff;
      length_in    = length_ff;
      no_frame_in  = no_frame_ff;
      out_wait_in  = out_wait_ff;
      out_ovf_in   = out_ovf_ff;

      if (commit_en) begin
         if (full) begin
            drop_in = 1'b1;
         end else begin
            head_in = next_head;
         end
      end

      if (read_acc) begin
         drop_in = 1'b0;
         if (!empty) begin
            tail_in    = next_tail;
            rd_slot_in = tail_ff;
            busy_in    = 1'b1;
            fetch_k_in = (KW + 1)'(1);
            data_k_in  = '0;
            avail_in   = 1'b1;
            waiting_in = WAIT_W'(stored);
            ovf_in     = drop_ff;
         end
      end else if (fetch_more) begin
         fetch_k_in = fetch_k_ff + 1'b1;
         data_k_in  = fetch_k_ff[KW-1:0];
         avail_in   = 1'b1;
      end else if (consume) begin
         avail_in = 1'b0;
      end

      if (consume && last_byte) begin
         busy_in = 1'b0;
      end

      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (consume) begin
         out_byte_in = slot_rdata;
         is_last_in  = last_byte;
         length_in   = len_rdata;
         no_frame_in = 1'b0;
         out_wait_in = waiting_ff;
         out_ovf_in  = ovf_ff;
      end else if (read_acc && empty) begin
         out_byte_in = '0;
         is_last_in  = 1'b1;
         length_in   = '0;
         no_frame_in = 1'b1;
         out_wait_in = '0;
         out_ovf_in  = drop_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         xor_ff       <= '0;
         count_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         drop_ff      <= 1'b0;
         busy_ff      <= 1'b0;
         avail_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         xor_ff       <= xor_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         drop_ff      <= drop_in;
         busy_ff      <= busy_in;
         avail_ff     <= avail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_slot_ff  <= rd_slot_in;
      fetch_k_ff  <= fetch_k_in;
      data_k_ff   <= data_k_in;
      waiting_ff  <= waiting_in;
      ovf_ff      <= ovf_in;
      out_byte_ff <= out_byte_in;
      is_last_ff  <= is_last_in;
      length_ff   <= length_in;
      no_frame_ff <= no_frame_in;
      out_wait_ff <= out_wait_in;
      out_ovf_ff  <= out_ovf_in;
   end

   dsefr_ram #(
      .WIDTH(8),
      .DEPTH(FRAME_SLOTS * (2 ** KW))
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (slot_we),
      .wr_addr(slot_waddr),
      .wr_data(slot_wdata),
      .rd_en  (slot_re),
      .rd_addr(slot_raddr),
      .rd_data(slot_rdata)
   );

   dsefr_ram #(
      .WIDTH(LEN_W),
      .DEPTH(FRAME_SLOTS)
   ) u_len_ram (
      .clock  (clock),
      .wr_en  (len_we),
      .wr_addr(head_ff),
      .wr_data(len_wdata),
      .rd_en  (read_acc && !empty),
      .rd_addr(tail_ff),
      .rd_data(len_rdata)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_byte       = out_byte_ff;
   assign rsp_is_last        = is_last_ff;
   assign rsp_frame_length   = length_ff;
   assign rsp_no_frame       = no_frame_ff;
   assign rsp_frames_waiting = out_wait_ff;
   assign rsp_overflow_seen  = out_ovf_ff;

endmodule

FILE: rtl/core/dsefr_checker.sv
module dsefr_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [7:0]                   rsp_out_byte,
   input logic                         rsp_is_last,
   input logic [dsefr_pkg::LEN_W-1:0]  rsp_frame_length,
   input logic                         rsp_no_frame,
   input logic [dsefr_pkg::WAIT_W-1:0] rsp_frames_waiting,
   input logic                         rsp_overflow_seen
);

   // An empty-ring result is a single beat with zeroed frame fields.
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_frame |->
         rsp_is_last && rsp_frame_length == '0 && rsp_out_byte == '0 &&
         rsp_frames_waiting == '0)
      else $error("empty-ring result carries frame data");

   a_frame_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_no_frame |-> rsp_frame_length != '0)
      else $error("stored frame reported with zero length");

   // No new request is taken while a frame is still being read out.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_last |-> !(req_valid && req_ready))
      else $error("request accepted in the middle of a frame");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_out_byte) && $stable(rsp_is_last) &&
         $stable(rsp_frame_length) && $stable(rsp_no_frame) &&
         $stable(rsp_frames_waiting) && $stable(rsp_overflow_seen))
      else $error("stalled result beat changed");

endmodule

bind dle_stx_etx_frame_receiver_top dsefr_checker u_dsefr_checker (.*);

FILE: dv/dle_stx_etx_frame_receiver_top_tb.sv
`timescale 1ns / 100ps

module dle_stx_etx_frame_receiver_top_tb;
   import dsefr_pkg::*;

   localparam int FRAME_SLOTS    = 8;
   localparam int MAX_DATA       = 63;
   localparam int SLOT_SIZE      = MAX_DATA + 1;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_OFF       = 300;
   localparam logic KIND_LINE    = 1'b0;
   localparam logic KIND_READ    = 1'b1;

   typedef logic [7:0] byte_q_type[$];

   typedef struct packed {
      logic [7:0]        out_byte;
      logic              is_last;
      logic [LEN_W-1:0]  frame_length;
      logic              no_frame;
      logic [WAIT_W-1:0] frames_waiting;
      logic              overflow_seen;
   } rsp_beat_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_kind = KIND_LINE;
   logic [7:0]        req_line_byte = 8'h00;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [7:0]        rsp_out_byte;
   logic              rsp_is_last;
   logic [LEN_W-1:0]  rsp_frame_length;
   logic              rsp_no_frame;
   logic [WAIT_W-1:0] rsp_frames_waiting;
   logic              rsp_overflow_seen;

   // Predicted state of the parser and of the frame ring.
   phase_type  parse_ph;
   logic [7:0] run_xor;
   int         asm_count;
   logic [7:0] asm_buf [SLOT_SIZE];
   logic [7:0] slot_mem [FRAME_SLOTS][SLOT_SIZE];
   int         slot_len [FRAME_SLOTS];
   int         wr_slot;
   int         rd_slot;
   logic       drop_flag;

   rsp_beat_type  pending_rsp[$];
   rsp_beat_type  seen_beat;
   rsp_beat_type  want_beat;

   int src_idle_pct = 0;
   int stall_pct    = 0;
   int hold_asks    = 0;
   int hold_taken   = 0;
   int hold_left    = 0;
   int quiet_cycles = 0;
   int error_count  = 0;
   int beats_sent   = 0;
   int rsp_checked  = 0;
   int frames_kept  = 0;
   int frames_lost  = 0;
   int frames_cut   = 0;
   int empty_reads  = 0;

   dle_stx_etx_frame_receiver_top #(
      .FRAME_SLOTS(FRAME_SLOTS),
      .MAX_DATA   (MAX_DATA)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_line_byte     (req_line_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_is_last       (rsp_is_last),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_no_frame      (rsp_no_frame),
      .rsp_frames_waiting(rsp_frames_waiting),
      .rsp_overflow_seen (rsp_overflow_seen)
   );

   always #6 clock = ~clock;

   task automatic take_data_byte(input logic [7:0] b);
      if (asm_count >= MAX_DATA) begin
         parse_ph  = PH_IDLE;
         asm_count = 0;
         frames_cut++;
      end else begin
         asm_buf[asm_count] = b;
         asm_count++;
         run_xor ^= b;
         parse_ph = PH_DATA;
      end
   endtask

   task automatic close_frame();
      int next;
      int len;
      next = (wr_slot + 1) % FRAME_SLOTS;
      asm_buf[asm_count] = run_xor;
      len = asm_count + 1;
      if (next == rd_slot) begin
         drop_flag = 1'b1;
         frames_lost++;
      end else begin
         for (int k = 0; k < len; k++) slot_mem[wr_slot][k] = asm_buf[k];
         slot_len[wr_slot] = len;
         wr_slot = next;
         frames_kept++;
      end
      asm_count = 0;
      parse_ph  = PH_SKIP;
   endtask

   task automatic parse_line_byte(input logic [7:0] b);
      case (parse_ph)
         PH_GOT_DLE: parse_ph = (b == SYM_STX) ? PH_DATA : PH_IDLE;
         PH_DATA: begin
            if (b == SYM_DLE) parse_ph = PH_ESCAPE;
            else take_data_byte(b);
         end
         PH_ESCAPE: begin
            if (b == SYM_ETX) close_frame();
            else if (b == SYM_DLE) take_data_byte(b);
            else parse_ph = PH_IDLE;
         end
         PH_SKIP: parse_ph = PH_IDLE;
         default: begin
            if (b == SYM_DLE) begin
               run_xor   = 8'h00;
               asm_count = 0;
               parse_ph  = PH_GOT_DLE;
            end else begin
               parse_ph = PH_IDLE;
            end
         end
      endcase
   endtask

   task automatic read_oldest_frame();
      rsp_beat_type beat;
      int len;
      logic [WAIT_W-1:0] waiting;
      if (wr_slot == rd_slot) begin
         beat.out_byte       = 8'h00;
         beat.is_last        = 1'b1;
         beat.frame_length   = '0;
         beat.no_frame       = 1'b1;
         beat.frames_waiting = '0;
         beat.overflow_seen  = drop_flag;
         pending_rsp.push_back(beat);
         empty_reads++;
      end else begin
         waiting = WAIT_W'((wr_slot + FRAME_SLOTS - rd_slot) % FRAME_SLOTS);
         len = slot_len[rd_slot];
         for (int k = 0; k < len; k++) begin
            beat.out_byte       = slot_mem[rd_slot][k];
            beat.is_last        = (k + 1 == len);
            beat.frame_length   = LEN_W'(len);
            beat.no_frame       = 1'b0;
            beat.frames_waiting = waiting;
            beat.overflow_seen  = drop_flag;
            pending_rsp.push_back(beat);
         end
         rd_slot = (rd_slot + 1) % FRAME_SLOTS;
      end
      drop_flag = 1'b0;
   endtask

   task automatic send_beat(input logic kind, input logic [7:0] b);
      @(negedge clock);
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_line_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
      if (kind == KIND_LINE) parse_line_byte(b);
      else read_oldest_frame();
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(7))
         0: return SYM_DLE;
         1: return SYM_STX;
         2: return SYM_ETX;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic byte_q_type random_payload(input int n);
      byte_q_type data;
      for (int k = 0; k < n; k++) data.push_back(pick_byte());
      return data;
   endfunction

   task automatic send_frame(input byte_q_type data, input logic [7:0] wire_check);
      send_beat(KIND_LINE, SYM_DLE);
      send_beat(KIND_LINE, SYM_STX);
      foreach (data[k]) begin
         if (data[k] == SYM_DLE) send_beat(KIND_LINE, SYM_DLE);
         send_beat(KIND_LINE, data[k]);
      end
      send_beat(KIND_LINE, SYM_DLE);
      send_beat(KIND_LINE, SYM_ETX);
      send_beat(KIND_LINE, wire_check);
   endtask

   task automatic send_read();
      send_beat(KIND_READ, 8'($urandom_range(255)));
   endtask

   task automatic drain_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic empty_the_ring();
      while (wr_slot != rd_slot) send_read();
   endtask

   task automatic test_empty_read();
      send_beat(KIND_READ, 8'hFF);
      drain_responses();
   endtask

   task automatic test_stuffing_and_extremes();
      send_frame('{8'h00, 8'hFF, SYM_DLE, SYM_STX, SYM_ETX}, SYM_DLE);
      send_beat(KIND_LINE, SYM_STX);
      send_beat(KIND_READ, 8'h00);
      drain_responses();
   endtask

   task automatic test_bad_escape_and_start();
      send_beat(KIND_LINE, SYM_DLE);
      send_beat(KIND_LINE, SYM_STX);
      send_beat(KIND_LINE, 8'h55);
      send_beat(KIND_LINE, SYM_DLE);
      send_beat(KIND_LINE, 8'hAA);
      send_beat(KIND_LINE, SYM_DLE);
      send_beat(KIND_LINE, 8'h05);
      send_beat(KIND_LINE, SYM_ETX);
      send_read();
      drain_responses();
   endtask

   task automatic test_empty_frame();
      byte_q_type no_data;
      send_frame(no_data, 8'h7E);
      send_read();
      send_read();
      drain_responses();
   endtask

   task automatic test_full_ring();
      empty_the_ring();
      for (int f = 0; f < FRAME_SLOTS + 1; f++)
         send_frame(random_payload($urandom_range(0, 2)), pick_byte());
      for (int r = 0; r < FRAME_SLOTS + 1; r++) send_read();
      drain_responses();
   endtask

   task automatic test_over_long_frame();
      empty_the_ring();
      send_frame(random_payload(MAX_DATA), pick_byte());
      send_frame(random_payload(MAX_DATA + 1), pick_byte());
      send_read();
      send_read();
      drain_responses();
   endtask

   task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n_beats);
      int stop;
      int sel;
      logic [7:0] bad;
      byte_q_type data;
      src_idle_pct = src_pct;
      stall_pct    = sink_pct;
      stop = beats_sent + n_beats;
      while (beats_sent < stop) begin
         sel = $urandom_range(99);
         if (sel < 50) begin
            send_frame(random_payload($urandom_range(0, 6)), pick_byte());
         end else if (sel < 78) begin
            send_read();
         end else if (sel < 86) begin
            repeat ($urandom_range(1, 4)) send_beat(KIND_LINE, pick_byte());
         end else if (sel < 96) begin
            data = random_payload($urandom_range(0, 4));
            send_beat(KIND_LINE, SYM_DLE);
            send_beat(KIND_LINE, SYM_STX);
            foreach (data[k]) begin
               if (data[k] == SYM_DLE) send_beat(KIND_LINE, SYM_DLE);
               send_beat(KIND_LINE, data[k]);
            end
            do bad = pick_byte(); while (bad == SYM_DLE || bad == SYM_ETX);
            send_beat(KIND_LINE, SYM_DLE);
            send_beat(KIND_LINE, bad);
         end else begin
            send_frame(random_payload($urandom_range(MAX_DATA - 2, MAX_DATA + 2)),
                       pick_byte());
         end
      end
      drain_responses();
   endtask

   task automatic test_backpressure();
      src_idle_pct = 0;
      stall_pct    = 0;
      send_frame(random_payload(5), pick_byte());
      send_frame(random_payload(3), pick_byte());
      hold_asks++;
      repeat (3) send_read();
      send_frame(random_payload(4), pick_byte());
      repeat (2) send_read();
      drain_responses();
   endtask

   always @(negedge clock) begin
      if (hold_asks != hold_taken) begin
         hold_taken <= hold_asks;
         hold_left  <= HOLD_OFF - 1;
         rsp_ready  <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_beat.out_byte       = rsp_out_byte;
         seen_beat.is_last        = rsp_is_last;
         seen_beat.frame_length   = rsp_frame_length;
         seen_beat.no_frame       = rsp_no_frame;
         seen_beat.frames_waiting = rsp_frames_waiting;
         seen_beat.overflow_seen  = rsp_overflow_seen;
         rsp_checked++;
         if (pending_rsp.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("%0t: response beat with none expected: byte %h last %b len %0d",
                        $time, rsp_out_byte, rsp_is_last, rsp_frame_length);
         end else begin
            want_beat = pending_rsp.pop_front();
            if (seen_beat.out_byte != want_beat.out_byte
                || seen_beat.is_last != want_beat.is_last
                || seen_beat.frame_length != want_beat.frame_length
                || seen_beat.no_frame != want_beat.no_frame
                || seen_beat.frames_waiting != want_beat.frames_waiting
                || seen_beat.overflow_seen != want_beat.overflow_seen) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("%0t: expected byte %h last %b len %0d empty %b wait %0d ovf %b",
                           $time, want_beat.out_byte, want_beat.is_last,
                           want_beat.frame_length, want_beat.no_frame,
                           want_beat.frames_waiting, want_beat.overflow_seen);
                  $display("%0t:      got byte %h last %b len %0d empty %b wait %0d ovf %b",
                           $time, seen_beat.out_byte, seen_beat.is_last,
                           seen_beat.frame_length, seen_beat.no_frame,
                           seen_beat.frames_waiting, seen_beat.overflow_seen);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d response beats outstanding.",
                  pending_rsp.size());
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      parse_ph  = PH_IDLE;
      run_xor   = 8'h00;
      asm_count = 0;
      wr_slot   = 0;
      rd_slot   = 0;
      drop_flag = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_read();
      test_stuffing_and_extremes();
      test_bad_escape_and_start();
      test_empty_frame();
      test_full_ring();
      test_over_long_frame();
      test_random_traffic(0, 0, 15);
      test_random_traffic(61, 0, 15);
      test_random_traffic(0, 61, 15);
      test_random_traffic(8, 8, 15);
      test_backpressure();

      drain_responses();
      repeat (10) @(posedge clock);
      $display("Sent %0d request beats and checked %0d response beats, %0d empty reads.",
               beats_sent, rsp_checked, empty_reads);
      $display("Frames stored %0d, dropped on a full ring %0d, cut as over-long %0d.",
               frames_kept, frames_lost, frames_cut);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d response beats never arrived.",
                  error_count, pending_rsp.size());
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
